FILE: hdl/kts_pkg.sv
// Shared constants for the keyframe track sampler.
package kts_pkg;
    localparam int COORD_W = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;
    localparam int SLOT_W  = 6;
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;
endpackage

FILE: hdl/kts_ram.sv
// Generic single-port synchronous RAM with registered read.
module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/kts_lerp.sv
// Sequential lerp unit: one signed multiply per cycle over six components.
module kts_lerp #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic signed [kts_pkg::COORD_W-1:0] a,
    input  logic signed [kts_pkg::COORD_W-1:0] b,
    input  logic [FRACTION_BITS-1:0]        f,
    output logic signed [kts_pkg::COORD_W-1:0] r
);
    import kts_pkg::*;
    logic signed [COORD_W:0]                 d_reg;
    logic signed [COORD_W-1:0]               a_reg;
    logic signed [COORD_W+FRACTION_BITS+1:0] p;
    always_ff @(posedge clk)
    begin
        d_reg <= {b[COORD_W-1], b} - {a[COORD_W-1], a};
        a_reg <= a;
    end
    // arithmetic shift gives floor
    assign p = d_reg * $signed({1'b0, f});
    assign r = a_reg + COORD_W'(p >>> FRACTION_BITS);
endmodule

FILE: hdl/keyframe_track_sampler_top.sv
// Top level of the keyframe track sampler.
// Usage: pulse start with opcode and payload when busy is low.
// A write transfer (opcode 0) stores time, position and scale of key_slot
// into three one-port RAMs and gives no result; busy stays high for one cycle.
// A sample transfer (opcode 1) walks the time RAM from key 0, one entry at a
// time (address, then compare the registered read), until a key later than
// sample_time or the last key in use. It then runs a restoring divider,
// one quotient bit per cycle, to form the Q0.16 factor, and finally reads
// the two keys of the segment and interpolates the six components, one
// multiply per cycle through a shared unit. Held results skip the divider.
// done rises in the same cycle as busy falls.
// The result shows on the out ports with done high for one cycle; the
// receiver cannot stall, and the next sample overwrites the result.
// key_count is written through cfg_we/cfg_data, by the user only while idle (the
// block does not enforce it); zero acts as one and values above MAX_KEYS saturate.
// Reset clears control state and sets key_count to one; key RAMs are
// undefined until written and no clearing pass is run.
module keyframe_track_sampler_top #(
    parameter int MAX_KEYS      = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic cfg_we,
    input  logic [kts_pkg::COUNT_W-1:0] cfg_data,
    input  logic [0:0] opcode,
    input  logic [kts_pkg::SLOT_W-1:0] key_slot,
    input  logic [kts_pkg::TIME_W-1:0] key_time,
    input  logic signed [kts_pkg::COORD_W-1:0] key_pos_x,
    input  logic signed [kts_pkg::COORD_W-1:0] key_pos_y,
    input  logic signed [kts_pkg::COORD_W-1:0] key_pos_z,
    input  logic signed [kts_pkg::COORD_W-1:0] key_scale_x,
    input  logic signed [kts_pkg::COORD_W-1:0] key_scale_y,
    input  logic signed [kts_pkg::COORD_W-1:0] key_scale_z,
    input  logic [kts_pkg::TIME_W-1:0] sample_time,
    output logic done,
    output logic signed [kts_pkg::COORD_W-1:0] out_pos_x,
    output logic signed [kts_pkg::COORD_W-1:0] out_pos_y,
    output logic signed [kts_pkg::COORD_W-1:0] out_pos_z,
    output logic signed [kts_pkg::COORD_W-1:0] out_scale_x,
    output logic signed [kts_pkg::COORD_W-1:0] out_scale_y,
    output logic signed [kts_pkg::COORD_W-1:0] out_scale_z,
    output logic [kts_pkg::SLOT_W-1:0] segment_index,
    output logic held_at_end
);
    import kts_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int DW = 3 * COORD_W;
    localparam int QC = $clog2(FRACTION_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_SRCH_RD, S_SRCH_CHK, S_T1_RD, S_T1_WAIT,
        S_DIV, S_LD_A, S_LD_B, S_MUL, S_FIN
    } state_t;

    state_t                state_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [NW-1:0]         n_eff;
    logic [AW-1:0]         addr_reg;
    logic [AW-1:0]         idx_reg;
    logic [TIME_W-1:0]     t_reg;
    logic                  we_reg;
    logic [TIME_W-1:0]     wt_reg;
    logic [DW-1:0]         wp_reg, ws_reg;
    logic [TIME_W-1:0]     rd_t;
    logic [DW-1:0]         rd_p, rd_s;
    logic [TIME_W:0]       rem_reg;
    logic [TIME_W-1:0]     span_reg;
    logic [FRACTION_BITS-1:0] q_reg;
    logic [QC-1:0]         qcnt_reg;
    logic [DW-1:0]         ap_reg, as_reg, bp_reg, bs_reg;
    logic [2:0]            comp_reg;
    logic [COORD_W-1:0]    res_reg [6];
    logic                  held_reg;
    logic                  done_reg;
    logic signed [COORD_W-1:0] mul_a, mul_b, mul_r;
    logic [TIME_W:0]       rem_sh;

    // saturate key_count into [1, MAX_KEYS]
    always_comb
    begin
        if (count_reg == '0)
            n_eff = NW'(1);
        else if (32'(count_reg) > MAX_KEYS)
            n_eff = NW'(MAX_KEYS);
        else
            n_eff = NW'(count_reg);
    end

    kts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time (
        .clk(clk), .we(we_reg), .addr(addr_reg), .wdata(wt_reg), .rdata(rd_t));
    kts_ram #(.WIDTH(DW), .DEPTH(MAX_KEYS)) u_pos (
        .clk(clk), .we(we_reg), .addr(addr_reg), .wdata(wp_reg), .rdata(rd_p));
    kts_ram #(.WIDTH(DW), .DEPTH(MAX_KEYS)) u_scale (
        .clk(clk), .we(we_reg), .addr(addr_reg), .wdata(ws_reg), .rdata(rd_s));

    // component select for the shared lerp unit
    always_comb
    begin
        case (comp_reg)
            3'd0: begin mul_a = ap_reg[31:0];  mul_b = bp_reg[31:0];  end
            3'd1: begin mul_a = ap_reg[63:32]; mul_b = bp_reg[63:32]; end
            3'd2: begin mul_a = ap_reg[95:64]; mul_b = bp_reg[95:64]; end
            3'd3: begin mul_a = as_reg[31:0];  mul_b = bs_reg[31:0];  end
            3'd4: begin mul_a = as_reg[63:32]; mul_b = bs_reg[63:32]; end
            3'd5: begin mul_a = as_reg[95:64]; mul_b = bs_reg[95:64]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    kts_lerp #(.FRACTION_BITS(FRACTION_BITS)) u_lerp (
        .clk(clk), .a(mul_a), .b(mul_b), .f(q_reg), .r(mul_r));

    assign rem_sh = {rem_reg[TIME_W-1:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= COUNT_W'(1);
            we_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            we_reg   <= 1'b0;
            if (cfg_we)
                count_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        t_reg <= sample_time;
                        if (opcode == OP_WRITE)
                        begin
                            // slot beyond storage is dropped
                            if (32'(key_slot) < MAX_KEYS)
                                we_reg <= 1'b1;
                            addr_reg  <= AW'(key_slot);
                            wt_reg    <= key_time;
                            wp_reg    <= {key_pos_z, key_pos_y, key_pos_x};
                            ws_reg    <= {key_scale_z, key_scale_y, key_scale_x};
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            addr_reg  <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_SRCH_RD;
                        end
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                S_SRCH_RD: state_reg <= S_SRCH_CHK;
                S_SRCH_CHK:
                begin
                    if (t_reg < rd_t)
                    begin
                        // key 0 later than t holds key 0, else segment ends here
                        if (addr_reg == '0)
                        begin
                            held_reg  <= 1'b1;
                            state_reg <= S_LD_A;
                        end
                        else
                        begin
                            held_reg  <= 1'b0;
                            idx_reg   <= addr_reg - AW'(1);
                            addr_reg  <= addr_reg - AW'(1);
                            span_reg  <= rd_t;
                            state_reg <= S_T1_RD;
                        end
                    end
                    else if (NW'(addr_reg) + NW'(1) >= n_eff)
                    begin
                        held_reg  <= 1'b1;
                        idx_reg   <= addr_reg;
                        state_reg <= S_LD_A;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + AW'(1);
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_T1_RD: state_reg <= S_T1_WAIT;
                S_T1_WAIT:
                begin
                    span_reg  <= span_reg - rd_t;
                    rem_reg   <= {1'b0, t_reg - rd_t};
                    qcnt_reg  <= '0;
                    q_reg     <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring divide: dt < span, so every step is one bit
                    if (rem_sh >= {1'b0, span_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, span_reg};
                        q_reg   <= {q_reg[FRACTION_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[FRACTION_BITS-2:0], 1'b0};
                    end
                    qcnt_reg <= qcnt_reg + QC'(1);
                    if (qcnt_reg == QC'(FRACTION_BITS - 1))
                        state_reg <= S_LD_A;
                end
                S_LD_A:
                begin
                    // read the start key
                    addr_reg  <= idx_reg;
                    comp_reg  <= '0;
                    state_reg <= S_LD_B;
                end
                S_LD_B:
                begin
                    addr_reg  <= idx_reg + AW'(1);
                    state_reg <= S_MUL;
                    comp_reg  <= 3'd7;
                end
                S_MUL:
                begin
                    if (comp_reg == 3'd7)
                    begin
                        ap_reg   <= rd_p;
                        as_reg   <= rd_s;
                        comp_reg <= 3'd6;
                    end
                    else if (comp_reg == 3'd6)
                    begin
                        bp_reg   <= held_reg ? ap_reg : rd_p;
                        bs_reg   <= held_reg ? as_reg : rd_s;
                        comp_reg <= 3'd0;
                    end
                    else
                    begin
                        if (held_reg)
                            q_reg <= '0;
                        comp_reg <= comp_reg + 3'd1;
                        if (comp_reg != 3'd0)
                            res_reg[comp_reg - 3'd1] <= mul_r;
                        if (comp_reg == 3'd5)
                            state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    res_reg[5] <= mul_r;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign out_pos_x     = res_reg[0];
    assign out_pos_y     = res_reg[1];
    assign out_pos_z     = res_reg[2];
    assign out_scale_x   = res_reg[3];
    assign out_scale_y   = res_reg[4];
    assign out_scale_z   = res_reg[5];
    assign segment_index = SLOT_W'(idx_reg);
    assign held_at_end   = held_reg;
endmodule

FILE: hdl/kts_checker.sv
// Port-level checker for the keyframe track sampler, bound to the top level.
module kts_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted transfer did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without work");
endmodule

bind keyframe_track_sampler_top kts_checker u_kts_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done));

FILE: verif/kts_result_checker.sv
// Result checker for the keyframe track sampler: predicts each sample and compares.
`timescale 1ns / 100ps

module kts_result_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               cfg_we,
    input  logic [kts_pkg::COUNT_W-1:0]        cfg_data,
    input  logic [0:0]                         opcode,
    input  logic [kts_pkg::SLOT_W-1:0]         key_slot,
    input  logic [kts_pkg::TIME_W-1:0]         key_time,
    input  logic signed [kts_pkg::COORD_W-1:0] key_pos_x,
    input  logic signed [kts_pkg::COORD_W-1:0] key_pos_y,
    input  logic signed [kts_pkg::COORD_W-1:0] key_pos_z,
    input  logic signed [kts_pkg::COORD_W-1:0] key_scale_x,
    input  logic signed [kts_pkg::COORD_W-1:0] key_scale_y,
    input  logic signed [kts_pkg::COORD_W-1:0] key_scale_z,
    input  logic [kts_pkg::TIME_W-1:0]         sample_time,
    input  logic                               done,
    input  logic signed [kts_pkg::COORD_W-1:0] out_pos_x,
    input  logic signed [kts_pkg::COORD_W-1:0] out_pos_y,
    input  logic signed [kts_pkg::COORD_W-1:0] out_pos_z,
    input  logic signed [kts_pkg::COORD_W-1:0] out_scale_x,
    input  logic signed [kts_pkg::COORD_W-1:0] out_scale_y,
    input  logic signed [kts_pkg::COORD_W-1:0] out_scale_z,
    input  logic [kts_pkg::SLOT_W-1:0]         segment_index,
    input  logic                               held_at_end,
    output int                                 errors,
    output int                                 pending
);
    import kts_pkg::*;

    localparam int TRACK_DEPTH = 64;
    localparam int FRAC        = 16;

    typedef struct {
        logic signed [COORD_W-1:0] comp[6];
        logic [SLOT_W-1:0]         seg;
        logic                      held;
    } track_sample_t;

    logic [TIME_W-1:0]         time_mem[TRACK_DEPTH];
    logic signed [COORD_W-1:0] comp_mem[TRACK_DEPTH][6];
    logic [COUNT_W-1:0]        track_len;
    track_sample_t             sample_queue[$];

    // Linear blend with the product floored at the fraction point.
    function automatic logic signed [COORD_W-1:0] blend(logic signed [COORD_W-1:0] a,
                                                        logic signed [COORD_W-1:0] b,
                                                        longint f);
        longint d;
        longint p;
        d = longint'(b) - longint'(a);
        p = d * f;
        return COORD_W'(longint'(a) + (p >>> FRAC));
    endfunction

    function automatic track_sample_t sample_track(logic [TIME_W-1:0] t);
        track_sample_t r;
        int n;
        int seg;
        longint dt;
        longint span;
        longint f;
        n = (track_len == 0) ? 1 : ((track_len > TRACK_DEPTH) ? TRACK_DEPTH : int'(track_len));
        if (t < time_mem[0])
        begin
            seg = 0;
            r.held = 1'b1;
        end
        else
        begin
            seg = n - 1;
            for (int j = 1; j < n; j++)
            begin
                if (t < time_mem[j])
                begin
                    seg = j - 1;
                    break;
                end
            end
            r.held = (seg == n - 1);
        end
        if (r.held)
        begin
            for (int c = 0; c < 6; c++) r.comp[c] = comp_mem[seg][c];
        end
        else
        begin
            dt   = longint'({32'd0, t - time_mem[seg]});
            span = longint'({32'd0, time_mem[seg+1] - time_mem[seg]});
            f    = (span != 0) ? (dt << FRAC) / span : 0;
            for (int c = 0; c < 6; c++) r.comp[c] = blend(comp_mem[seg][c], comp_mem[seg+1][c], f);
        end
        r.seg = SLOT_W'(seg);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] act);
        if (expv !== act)
        begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, expv, act);
            errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        track_sample_t e;
        if (!rst_n)
        begin
            track_len = 1;
            sample_queue.delete();
            pending = 0;
        end
        else
        begin
            // Compare the result transfer against the oldest prediction.
            if (done)
            begin
                if (sample_queue.size() == 0)
                begin
                    $error("result transfer with no sample outstanding");
                    errors++;
                end
                else
                begin
                    e = sample_queue.pop_front();
                    check_field("out_pos_x",   e.comp[0], out_pos_x);
                    check_field("out_pos_y",   e.comp[1], out_pos_y);
                    check_field("out_pos_z",   e.comp[2], out_pos_z);
                    check_field("out_scale_x", e.comp[3], out_scale_x);
                    check_field("out_scale_y", e.comp[4], out_scale_y);
                    check_field("out_scale_z", e.comp[5], out_scale_z);
                    check_field("segment_index", 32'(e.seg), 32'(segment_index));
                    check_field("held_at_end", 32'(e.held), 32'(held_at_end));
                end
            end
            if (cfg_we) track_len = cfg_data;
            if (start && !busy)
            begin
                if (opcode == OP_WRITE)
                begin
                    time_mem[key_slot]    = key_time;
                    comp_mem[key_slot][0] = key_pos_x;
                    comp_mem[key_slot][1] = key_pos_y;
                    comp_mem[key_slot][2] = key_pos_z;
                    comp_mem[key_slot][3] = key_scale_x;
                    comp_mem[key_slot][4] = key_scale_y;
                    comp_mem[key_slot][5] = key_scale_z;
                end
                else
                begin
                    sample_queue.push_back(sample_track(sample_time));
                end
            end
            pending = sample_queue.size();
        end
    end
endmodule

FILE: verif/testbench.sv
// Top of the keyframe track sampler testbench: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
    import kts_pkg::*;

    localparam int TRACK_DEPTH = 64;
    localparam int WATCHDOG    = 20000;
    localparam int DRAIN       = 200;   // outlasts the longest sample

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      cfg_we = 1'b0;
    logic [COUNT_W-1:0]        cfg_data = '0;
    logic [0:0]                opcode = OP_WRITE;
    logic [SLOT_W-1:0]         key_slot = '0;
    logic [TIME_W-1:0]         key_time = '0;
    logic signed [COORD_W-1:0] key_pos_x = '0;
    logic signed [COORD_W-1:0] key_pos_y = '0;
    logic signed [COORD_W-1:0] key_pos_z = '0;
    logic signed [COORD_W-1:0] key_scale_x = '0;
    logic signed [COORD_W-1:0] key_scale_y = '0;
    logic signed [COORD_W-1:0] key_scale_z = '0;
    logic [TIME_W-1:0]         sample_time = '0;
    logic                      done;
    logic signed [COORD_W-1:0] out_pos_x;
    logic signed [COORD_W-1:0] out_pos_y;
    logic signed [COORD_W-1:0] out_pos_z;
    logic signed [COORD_W-1:0] out_scale_x;
    logic signed [COORD_W-1:0] out_scale_y;
    logic signed [COORD_W-1:0] out_scale_z;
    logic [SLOT_W-1:0]         segment_index;
    logic                      held_at_end;
    int                        errors;
    int                        pending;

    // Stimulus-side bookkeeping: key times of the current track, used only
    // to aim sample times at interesting spots.
    logic [TIME_W-1:0] track_time[TRACK_DEPTH];
    int                track_keys = 1;
    int                idle_pct = 0;
    int                n_writes = 0;
    int                n_samples = 0;
    int                n_phases = 0;
    int                quiet_cycles = 0;

    always #5 clk = ~clk;

    keyframe_track_sampler_top dut (.*);

    kts_result_checker checker_i (.*);

    // Watchdog: count cycles in which no transfer of any kind happens.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("keyframe_track_sampler_top test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item and hold it until the block takes it. Start stays
    // high across back-to-back transfers; drop it only for an idle gap.
    task automatic send_item(logic [0:0] op, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] kt,
                             logic [5:0][COORD_W-1:0] vals, logic [TIME_W-1:0] st);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        key_slot    <= slot;
        key_time    <= kt;
        key_pos_x   <= vals[0];
        key_pos_y   <= vals[1];
        key_pos_z   <= vals[2];
        key_scale_x <= vals[3];
        key_scale_y <= vals[4];
        key_scale_z <= vals[5];
        sample_time <= st;
        do @(posedge clk); while (busy);
        if (op == OP_WRITE) n_writes++;
        else n_samples++;
    endtask

    task automatic write_key(logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] kt,
                             logic [5:0][COORD_W-1:0] vals);
        send_item(OP_WRITE, slot, kt, vals, $urandom);
        track_time[slot] = kt;
    endtask

    task automatic sample_at(logic [TIME_W-1:0] st);
        send_item(OP_SAMPLE, SLOT_W'($urandom), $urandom, {$urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom}, st);
    endtask

    // Drain all outstanding samples, let a trailing write settle, then
    // update the key count while the block is idle.
    task automatic set_key_count(logic [COUNT_W-1:0] value);
        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        track_keys = (value == 0) ? 1 : ((value > TRACK_DEPTH) ? TRACK_DEPTH : int'(value));
    endtask

    function automatic logic [COORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($signed($urandom_range(20000)) - 10000) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0][COORD_W-1:0] pick_key();
        logic [5:0][COORD_W-1:0] v;
        for (int c = 0; c < 6; c++) v[c] = pick_value();
        return v;
    endfunction

    // Write a whole track of ascending times, with the odd repeated time
    // and a mix of short and long segments.
    task automatic build_track();
        longint t;
        t = ($urandom_range(3) == 0) ? 0 : $urandom_range(32'h00FF_FFFF);
        for (int i = 0; i < track_keys; i++)
        begin
            write_key(SLOT_W'(i), TIME_W'(t), pick_key());
            case ($urandom_range(7))
                0:       t += 0;
                1:       t += 1;
                2:       t += $urandom_range(32'h0FFF_FFFF);
                default: t += $urandom_range(5000) + 1;
            endcase
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        end
    endtask

    function automatic logic [TIME_W-1:0] pick_sample_time();
        int k;
        k = $urandom_range(track_keys - 1);
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return track_time[k];
            3:       return track_time[0] - 1;
            4:       return track_time[track_keys-1] + $urandom_range(3);
            5:       return $urandom;
            default: return track_time[k] + $urandom_range(6000);
        endcase
    endfunction

    initial
    begin
        logic [COUNT_W-1:0] counts[10];
        int pattern[4];
        counts  = '{7'd64, 7'd127, 7'd0, 7'd2, 7'd5, 7'd17, 7'd33, 7'd1, 7'd9, 7'd64};
        pattern = '{0, 79, 0, 7};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single key after reset, before / at / after it.
        write_key(6'd0, 100, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1_0000, 32'hFFFF_FFFF,
                  32'h5});
        sample_at(0);
        sample_at(100);
        sample_at(32'hFFFF_FFFF);
        write_key(6'd63, 32'hFFFF_FFFF, {32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h0,
                  32'h0});

        // Directed: four keys with full-range swings, a repeated time and a
        // last key at the top of the time range.
        set_key_count(7'd4);
        write_key(6'd1, 200, {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1,
                  32'h8000_0000});
        write_key(6'd2, 200, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        write_key(6'd3, 32'hFFFF_FFFF, {32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                  32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        sample_at(99);
        sample_at(101);
        sample_at(150);
        sample_at(199);
        sample_at(200);
        sample_at(201);
        sample_at(32'h8000_0000);
        sample_at(32'hFFFF_FFFE);
        sample_at(32'hFFFF_FFFF);

        // Random phases: new key count, a fresh track, then mostly samples
        // with some key rewrites anywhere in the storage.
        foreach (counts[p])
        begin
            set_key_count(counts[p]);
            idle_pct = pattern[p % 4];
            n_phases++;
            build_track();
            for (int i = 0; i < 75; i++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    write_key(SLOT_W'($urandom_range(TRACK_DEPTH - 1)),
                              $urandom_range(2) == 0 ? $urandom : pick_sample_time(),
                              pick_key());
                end
                else
                begin
                    sample_at(pick_sample_time());
                end
            end
        end

        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d key writes and %0d samples over %0d key-count phases,",
                 n_writes, n_samples, n_phases);
        $display("including zero, one, full and saturated key counts");
        if (errors == 0)
        begin
            $display("keyframe_track_sampler_top test passed");
        end
        else
        begin
            $display("keyframe_track_sampler_top test failed");
        end
        $finish;
    end
endmodule
